[hdl/c2p_pkg.sv]
// shared types, constants and the cordic arctangent table
package c2p_pkg;

	localparam int COORD_BITS       = 16;
	localparam int ANGLE_FRAC_BITS  = 13;
	localparam int RADIUS_FRAC_BITS = 8;
	localparam int RADIUS_BITS      = 24;
	localparam int ANGLE_BITS       = 16;

	localparam int CORDIC_STEPS = 30;
	localparam int SQRT_STEPS   = 24;
	localparam int SQRT_TOP     = 46;
	localparam int NORM_MSB     = 60;
	localparam int ANGLE_SH     = NORM_MSB - ANGLE_FRAC_BITS;

	localparam logic [30:0] PI_Q29     = 31'd1686629713;
	localparam logic [31:0] BIN_PI     = 32'h8000_0000;
	localparam logic [31:0] BIN_PI_HALF = 32'h4000_0000;

	typedef struct packed {
		logic [63:0] x;
		logic [63:0] y;
		logic [32:0] z;
		logic [48:0] n;
		logic [48:0] q;
		logic        xneg;
		logic        yneg;
		logic        xz;
		logic        yz;
	} c2p_pipe_t;

	function automatic logic [32:0] atan_step(input int i);
		logic [32:0] a;
		case (i)
			0:  a = 33'h020000000;
			1:  a = 33'h012E4051E;
			2:  a = 33'h009FB385B;
			3:  a = 33'h0051111D4;
			4:  a = 33'h0028B0D43;
			5:  a = 33'h00145D7E1;
			6:  a = 33'h000A2F61E;
			7:  a = 33'h000517C55;
			8:  a = 33'h00028BE53;
			9:  a = 33'h000145F2F;
			10: a = 33'h0000A2F98;
			11: a = 33'h0000517CC;
			12: a = 33'h000028BE6;
			13: a = 33'h0000145F3;
			14: a = 33'h00000A2FA;
			15: a = 33'h00000517D;
			16: a = 33'h0000028BE;
			17: a = 33'h00000145F;
			18: a = 33'h000000A30;
			19: a = 33'h000000518;
			20: a = 33'h00000028C;
			21: a = 33'h000000146;
			22: a = 33'h0000000A3;
			23: a = 33'h000000051;
			24: a = 33'h000000029;
			25: a = 33'h000000014;
			26: a = 33'h00000000A;
			27: a = 33'h000000005;
			28: a = 33'h000000003;
			29: a = 33'h000000001;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

[hdl/cartesian_to_polar.sv]
// cartesian to polar top level: front, cordic and sqrt stage chain, back, output buffer
// the chain has 37 register stages (3 front, 30 cordic, 3 back, 1 output) between the
// input word on s_axis and the result word on m_axis
// throughput: one word per cycle while m_axis_tready is high, every stage holds one word and
// the chain stalls only while the output skid register is full
// arst_n clears all valid bits, including those of the output buffer; payload registers are not reset
module cartesian_to_polar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // x_coord, y_coord
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // radius, angle
);
	import c2p_pkg::*;

	logic      en;
	logic      v [0:CORDIC_STEPS];
	c2p_pipe_t d [0:CORDIC_STEPS];
	logic      bv;
	logic [RADIUS_BITS-1:0] radius;
	logic [ANGLE_BITS-1:0]  angle;

	assign s_axis_tready = en;

	c2p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.x_coord   (s_axis_tdata[15:0]),
		.y_coord   (s_axis_tdata[31:16]),
		.out_valid (v[0]),
		.out_d     (d[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
		c2p_stage #(.STEP(i)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v[i]),
			.in_d      (d[i]),
			.out_valid (v[i+1]),
			.out_d     (d[i+1])
		);
	end

	c2p_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v[CORDIC_STEPS]),
		.in_d      (d[CORDIC_STEPS]),
		.out_valid (bv),
		.radius    (radius),
		.angle     (angle)
	);

	c2p_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (bv),
		.in_data       ({angle, radius}),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

[hdl/c2p_front.sv]
// front stages: magnitudes, squares, normalizing shift and sqrt operand
module c2p_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [15:0]            x_coord,
	input  logic [15:0]            y_coord,
	output logic                   out_valid,
	output c2p_pkg::c2p_pipe_t     out_d
);
	import c2p_pkg::*;

	logic [COORD_BITS-1:0] ax_s1, ay_s1;
	logic                  xneg_s1, yneg_s1, xz_s1, yz_s1, v_s1;

	logic [COORD_BITS-1:0] ax_s2, ay_s2;
	logic [31:0]           sqx_s2, sqy_s2;
	logic [5:0]            sh_s2;
	logic                  xneg_s2, yneg_s2, xz_s2, yz_s2, v_s2;

	c2p_pipe_t             d_s3;
	logic                  v_s3;

	logic [COORD_BITS-1:0] big;
	logic [3:0]            msb;
	logic [32:0]           ssum;

	always_comb begin
		big = (ax_s1 > ay_s1) ? ax_s1 : ay_s1;
		msb = '0;
		for (int i = 0; i < COORD_BITS; i++) begin
			if (big[i]) begin
				msb = 4'(i);
			end
		end
	end

	assign ssum = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= x_coord[15] ? (16'd0 - x_coord) : x_coord;
			ay_s1   <= y_coord[15] ? (16'd0 - y_coord) : y_coord;
			xneg_s1 <= x_coord[15];
			yneg_s1 <= y_coord[15];
			xz_s1   <= (x_coord == 16'd0);
			yz_s1   <= (y_coord == 16'd0);

			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			sqx_s2  <= {16'd0, ax_s1} * {16'd0, ax_s1};
			sqy_s2  <= {16'd0, ay_s1} * {16'd0, ay_s1};
			sh_s2   <= 6'(NORM_MSB) - {2'b00, msb};
			xneg_s2 <= xneg_s1;
			yneg_s2 <= yneg_s1;
			xz_s2   <= xz_s1;
			yz_s2   <= yz_s1;

			d_s3.x    <= {48'd0, ax_s2} << sh_s2;
			d_s3.y    <= {48'd0, ay_s2} << sh_s2;
			d_s3.z    <= '0;
			d_s3.n    <= 49'({ssum, {(2*RADIUS_FRAC_BITS){1'b0}}});
			d_s3.q    <= '0;
			d_s3.xneg <= xneg_s2;
			d_s3.yneg <= yneg_s2;
			d_s3.xz   <= xz_s2;
			d_s3.yz   <= yz_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_d     = d_s3;

endmodule

[hdl/c2p_stage.sv]
// one pipeline stage: a cordic vectoring step and, in the first SQRT_STEPS stages, a square root digit step
module c2p_stage #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  c2p_pkg::c2p_pipe_t in_d,
	output logic               out_valid,
	output c2p_pkg::c2p_pipe_t out_d
);
	import c2p_pkg::*;

	localparam bit          SQ_ON  = (STEP < SQRT_STEPS);
	localparam int          SQ_SH  = SQ_ON ? (SQRT_TOP - 2 * STEP) : 0;
	localparam logic [48:0] SQ_BIT = 49'd1 << SQ_SH;
	localparam logic [32:0] ATAN   = atan_step(STEP);

	logic signed [63:0] x, y, dx, dy;
	logic [48:0]        t;
	c2p_pipe_t          nxt;
	c2p_pipe_t          d_s1;
	logic               v_s1;

	always_comb begin
		x   = $signed(in_d.x);
		y   = $signed(in_d.y);
		dx  = y >>> STEP;
		dy  = x >>> STEP;
		t   = in_d.q + SQ_BIT;
		nxt = in_d;
		if (y > 64'sd0) begin
			nxt.x = x + dx;
			nxt.y = y - dy;
			nxt.z = in_d.z + ATAN;
		end else if (y < 64'sd0) begin
			nxt.x = x - dx;
			nxt.y = y + dy;
			nxt.z = in_d.z - ATAN;
		end
		if (SQ_ON) begin
			if (in_d.n >= t) begin
				nxt.n = in_d.n - t;
				nxt.q = (in_d.q >> 1) + SQ_BIT;
			end else begin
				nxt.q = in_d.q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_d     = d_s1;

endmodule

[hdl/c2p_back.sv]
// back stages: quadrant fold, radius rounding, scaling by pi and angle rounding
module c2p_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  c2p_pkg::c2p_pipe_t in_d,
	output logic               out_valid,
	output logic [23:0]        radius,
	output logic [15:0]        angle
);
	import c2p_pkg::*;

	logic [31:0]            mag;
	logic                   neg;
	logic [33:0]            fold;

	logic [31:0]            mag_s1;
	logic                   neg_s1, v_s1;
	logic [RADIUS_BITS-1:0] rad_s1;

	logic [62:0]            prod_s2;
	logic                   neg_s2, v_s2;
	logic [RADIUS_BITS-1:0] rad_s2;

	logic [ANGLE_BITS-1:0]  ang_s3;
	logic [RADIUS_BITS-1:0] rad_s3;
	logic                   v_s3;

	logic [63:0]            rsum;
	logic [16:0]            r, rn;
	logic [ANGLE_BITS-1:0]  ang;

	always_comb begin
		fold = {2'b00, BIN_PI} - {1'b0, in_d.z};
		mag  = '0;
		neg  = 1'b0;
		if (in_d.xz && in_d.yz) begin
			mag = '0;
		end else if (in_d.xz) begin
			mag = BIN_PI_HALF;
			neg = in_d.yneg;
		end else if (in_d.yz) begin
			mag = in_d.xneg ? BIN_PI : 32'd0;
			neg = in_d.xneg;
		end else begin
			mag = in_d.xneg ? fold[31:0] : in_d.z[31:0];
			neg = in_d.yneg;
		end
	end

	always_comb begin
		rsum = {1'b0, prod_s2} + (64'd1 << (ANGLE_SH - 1));
		r    = rsum[ANGLE_SH+16:ANGLE_SH];
		rn   = 17'd0 - r;
		if (neg_s2) begin
			ang = (r > 17'd32768) ? 16'h8000 : rn[15:0];
		end else begin
			ang = (r > 17'd32767) ? 16'h7FFF : r[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag;
			neg_s1  <= neg;
			rad_s1  <= in_d.q[RADIUS_BITS-1:0] + RADIUS_BITS'(in_d.n > in_d.q);

			prod_s2 <= {31'd0, mag_s1} * {32'd0, PI_Q29};
			neg_s2  <= neg_s1;
			rad_s2  <= rad_s1;

			ang_s3  <= ang;
			rad_s3  <= rad_s2;
		end
	end

	assign out_valid = v_s3;
	assign radius    = rad_s3;
	assign angle     = ang_s3;

endmodule

[hdl/c2p_outbuf.sv]
// output register with skid stage, gives the pipeline enable
module c2p_outbuf (
	input  logic        clk,
	input  logic        arst_n,
	output logic        en,
	input  logic        in_valid,
	input  logic [39:0] in_data,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata
);
	logic        o_v_q, skid_v_q;
	logic [39:0] o_q, skid_q;

	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q    <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_axis_tready) begin
				skid_v_q <= 1'b0;
			end
		end else if (!o_v_q || m_axis_tready) begin
			o_v_q <= in_valid;
		end else begin
			skid_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_axis_tready) begin
				o_q <= skid_q;
			end
		end else if (!o_v_q || m_axis_tready) begin
			o_q <= in_data;
		end else begin
			skid_q <= in_data;
		end
	end

	assign m_axis_tvalid = o_v_q;
	assign m_axis_tdata  = o_q;

endmodule
